// ===== hdl/fera_pkg.sv =====
// shared types and codes for the free extent range allocator
// no dependencies; used by fera_cell and free_extent_range_allocator
package fera_pkg;

    // command broadcast to every cell of the extent chain
    typedef enum logic [2:0] {
        CELL_HOLD,
        CELL_LOAD,
        CELL_ALLOC,
        CELL_INSERT,
        CELL_SETTLE
    } t_cell_op;

    typedef struct packed {
        t_cell_op op;
        logic     split_any;
        logic     hole_any;
    } t_cell_ctl;

    // what a cell shows its upper neighbor
    typedef struct packed {
        logic valid;
        logic gt;
        logic split;
        logic mcan;
        logic mgo;
    } t_link;

    // per cell status gathered by the sequencer
    typedef struct packed {
        logic contain;
        logic split;
        logic drop;
        logic touch;
        logic hole;
    } t_cell_flags;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_SETTLE,
        S_DONE
    } t_state;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_RANGE = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

endpackage

// ===== hdl/fera_cell.sv =====
// one slot of the sorted free extent chain: start, end and valid bit
// depends on fera_pkg; instantiated in a row by free_extent_range_allocator
module fera_cell import fera_pkg::*; #(
    parameter int ADDR_BITS = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_bottom,
    input  t_cell_ctl            i_ctl,
    input  logic [ADDR_BITS-1:0] i_rs,
    input  logic [ADDR_BITS+1:0] i_re,
    input  logic [ADDR_BITS:0]   i_load_end,
    input  logic [ADDR_BITS:0]   i_rst_end,
    input  t_link                i_dn,
    input  logic [ADDR_BITS-1:0] i_dn_s,
    input  logic [ADDR_BITS:0]   i_dn_e,
    input  logic                 i_up_valid,
    input  logic [ADDR_BITS-1:0] i_up_s,
    input  logic [ADDR_BITS:0]   i_up_e,
    output t_link                o_link,
    output logic [ADDR_BITS-1:0] o_s,
    output logic [ADDR_BITS:0]   o_e,
    output t_cell_flags          o_flags
);

    logic                 r_valid, n_valid;
    logic [ADDR_BITS-1:0] r_s, n_s;
    logic [ADDR_BITS:0]   r_e, n_e;

    logic gt, contain, left, right, split, drop, touch, mcan, mgo, hole;

    always_comb begin
        gt      = r_valid && (r_s > i_rs);
        contain = r_valid && (r_s <= i_rs) && (i_re <= {1'b0, r_e});
        left    = (r_s != i_rs);
        right   = (i_re != {1'b0, r_e});
        split   = contain && left && right;
        drop    = contain && !left && !right;
        touch   = r_valid && ({2'b00, r_s} <= i_re) && (r_e >= {1'b0, i_rs});
        mcan    = r_valid && i_up_valid && (r_e >= {1'b0, i_up_s});
        mgo     = mcan && !i_dn.mcan;
        hole    = !r_valid && i_up_valid;
    end

    always_comb begin
        n_valid = r_valid;
        n_s     = r_s;
        n_e     = r_e;
        unique case (i_ctl.op)
            CELL_LOAD: begin
                n_valid = i_bottom && (i_load_end != '0);
                n_s     = '0;
                n_e     = i_load_end;
            end
            CELL_ALLOC: begin
                if (i_dn.split) begin
                    // upper piece of a split lands here
                    n_valid = 1'b1;
                    n_s     = i_re[ADDR_BITS-1:0];
                    n_e     = i_dn_e;
                end else if (i_ctl.split_any && i_dn.gt) begin
                    n_valid = i_dn.valid;
                    n_s     = i_dn_s;
                    n_e     = i_dn_e;
                end else if (contain) begin
                    if (drop) begin
                        n_valid = 1'b0;
                    end else if (!left) begin
                        n_s = i_re[ADDR_BITS-1:0];
                    end else begin
                        n_e = {1'b0, i_rs};
                    end
                end
            end
            CELL_INSERT: begin
                if (i_dn.gt) begin
                    n_valid = i_dn.valid;
                    n_s     = i_dn_s;
                    n_e     = i_dn_e;
                end else if (i_dn.valid && (gt || !r_valid)) begin
                    n_valid = 1'b1;
                    n_s     = i_rs;
                    n_e     = i_re[ADDR_BITS:0];
                end
            end
            CELL_SETTLE: begin
                if (i_ctl.hole_any) begin
                    // valid entries sink one slot toward the bottom
                    if (!r_valid && i_up_valid) begin
                        n_valid = 1'b1;
                        n_s     = i_up_s;
                        n_e     = i_up_e;
                    end else if (r_valid && !i_dn.valid) begin
                        n_valid = 1'b0;
                    end
                end else if (mgo) begin
                    n_e = (i_up_e > r_e) ? i_up_e : r_e;
                end else if (i_dn.mgo) begin
                    n_valid = 1'b0;
                end
            end
            default: begin
                n_valid = r_valid;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= i_bottom;
            r_s     <= '0;
            r_e     <= i_rst_end;
        end else begin
            r_valid <= n_valid;
            r_s     <= n_s;
            r_e     <= n_e;
        end
    end

    assign o_link  = '{valid: r_valid, gt: gt, split: split, mcan: mcan, mgo: mgo};
    assign o_s     = r_s;
    assign o_e     = r_e;
    assign o_flags = '{contain: contain, split: split, drop: drop, touch: touch, hole: hole};

endmodule

// ===== hdl/free_extent_range_allocator.sv =====
// free extent range allocator: sequencer, output register and the cell chain
// depends on fera_pkg and fera_cell
//
//   input channel: i_valid / o_stall carry one word (i_cmd, i_range_start,
//   i_range_length); the word is taken on a clock edge with i_valid high and
//   o_stall low. i_cmd 0 allocates the range, 1 frees it
//   output channel: o_valid / i_stall carry one word per command (o_status,
//   o_extent_count); o_status 0 ok, 1 range rejected, 2 table full
//   config: i_memory_size_we writes i_memory_size and reloads the table with
//   one free extent covering the saturated size; user writes it only while idle
//   timing: one command in flight; a reject goes from evaluation straight to
//   the finish state, while a trim, split or free also passes the settle
//   state, which takes each merge or compaction step in turn; entries move
//   one slot per cycle, so a dropped extent leaves a hole that climbs to the
//   top of the valid entries, and each absorbed extent a merge step and then
//   such a climb; o_stall falls as o_valid rises and the next word can be taken
//   a stall holds the result; the next word is still accepted, and once it
//   finishes the sequencer waits in its finish state
//   reset: synchronous, active low; table holds one extent of 65536 units
//   (saturated to the address range), no result pending
module free_extent_range_allocator import fera_pkg::*; #(
    parameter int MAX_EXTENTS = 64,
    parameter int ADDR_BITS   = 16
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_memory_size_we,
    input  logic [ADDR_BITS:0]                   i_memory_size,
    input  logic                                 i_valid,
    output logic                                 o_stall,
    input  logic                                 i_cmd,
    input  logic [ADDR_BITS-1:0]                 i_range_start,
    input  logic [ADDR_BITS:0]                   i_range_length,
    output logic                                 o_valid,
    input  logic                                 i_stall,
    output logic [1:0]                           o_status,
    output logic [$clog2(MAX_EXTENTS+1)-1:0]     o_extent_count
);

    localparam int NC    = MAX_EXTENTS + 1;            // one spare slot for a free
    localparam int CNT_W = $clog2(MAX_EXTENTS + 1);
    localparam int ICW   = $clog2(MAX_EXTENTS + 2);
    localparam logic [ADDR_BITS:0] FULL_SIZE = {1'b1, {ADDR_BITS{1'b0}}};
    localparam logic [ADDR_BITS:0] RST_END   =
        (ADDR_BITS >= 16) ? (ADDR_BITS+1)'(32'd65536) : FULL_SIZE;
    localparam logic [ICW-1:0] CNT_MAX = ICW'(MAX_EXTENTS);

    // memory size saturated to the address range
    function automatic logic [ADDR_BITS:0] sat_size(input logic [ADDR_BITS:0] v);
        logic [ADDR_BITS:0] res;
        res = v;
        if (v[ADDR_BITS] && (v[ADDR_BITS-1:0] != '0)) begin
            res = FULL_SIZE;
        end
        return res;
    endfunction

    t_state               r_state, n_state;
    logic                 r_cmd;
    logic                 r_zero;
    logic [ADDR_BITS-1:0] r_rs;
    logic [ADDR_BITS+1:0] r_re;
    logic [ADDR_BITS:0]   r_eff, n_eff;
    logic [ICW-1:0]       r_count, n_count;
    logic [1:0]           r_status;
    logic                 r_ovalid, n_ovalid;
    logic [1:0]           r_ostatus;
    logic [CNT_W-1:0]     r_ocount;

    t_cell_ctl          ctl;
    logic [ADDR_BITS:0] load_end;
    logic [1:0]         ex_status;
    logic               accept, out_free;

    // chain wiring
    t_link                w_link  [NC];
    logic [ADDR_BITS-1:0] w_s     [NC];
    logic [ADDR_BITS:0]   w_e     [NC];
    t_cell_flags          w_flags [NC];
    logic [NC-1:0] contain_v, split_v, drop_v, touch_v, hole_v, merge_v;
    logic any_contain, any_split, any_drop, any_touch, any_hole, any_merge;

    genvar j;
    generate
        for (j = 0; j < NC; j++) begin : g_cell
            t_link                dn;
            logic [ADDR_BITS-1:0] dn_s;
            logic [ADDR_BITS:0]   dn_e;
            logic                 up_valid;
            logic [ADDR_BITS-1:0] up_s;
            logic [ADDR_BITS:0]   up_e;

            if (j == 0) begin : g_bot
                // bottom sees a solid floor: never a gap, never a merge
                assign dn   = '{valid: 1'b1, gt: 1'b0, split: 1'b0, mcan: 1'b0, mgo: 1'b0};
                assign dn_s = '0;
                assign dn_e = '0;
            end else begin : g_mid
                assign dn   = w_link[j-1];
                assign dn_s = w_s[j-1];
                assign dn_e = w_e[j-1];
            end
            if (j == NC - 1) begin : g_top
                assign up_valid = 1'b0;
                assign up_s     = '0;
                assign up_e     = '0;
            end else begin : g_low
                assign up_valid = w_link[j+1].valid;
                assign up_s     = w_s[j+1];
                assign up_e     = w_e[j+1];
            end

            fera_cell #(
                .ADDR_BITS (ADDR_BITS)
            ) u_cell (
                .i_clk      (i_clk),
                .i_rst_n    (i_rst_n),
                .i_bottom   (j == 0),
                .i_ctl      (ctl),
                .i_rs       (r_rs),
                .i_re       (r_re),
                .i_load_end (load_end),
                .i_rst_end  (RST_END),
                .i_dn       (dn),
                .i_dn_s     (dn_s),
                .i_dn_e     (dn_e),
                .i_up_valid (up_valid),
                .i_up_s     (up_s),
                .i_up_e     (up_e),
                .o_link     (w_link[j]),
                .o_s        (w_s[j]),
                .o_e        (w_e[j]),
                .o_flags    (w_flags[j])
            );

            assign contain_v[j] = w_flags[j].contain;
            assign split_v[j]   = w_flags[j].split;
            assign drop_v[j]    = w_flags[j].drop;
            assign touch_v[j]   = w_flags[j].touch;
            assign hole_v[j]    = w_flags[j].hole;
            assign merge_v[j]   = w_link[j].mgo;
        end
    endgenerate

    assign any_contain = |contain_v;
    assign any_split   = |split_v;
    assign any_drop    = |drop_v;
    assign any_touch   = |touch_v;
    assign any_hole    = |hole_v;
    assign any_merge   = |merge_v;

    assign accept   = i_valid && !o_stall;
    assign out_free = !r_ovalid || !i_stall;

    // verdict of the evaluate cycle
    always_comb begin
        ex_status = ST_OK;
        if (r_zero) begin
            ex_status = ST_RANGE;
        end else if (r_cmd == CMD_ALLOC) begin
            if (!any_contain) begin
                ex_status = ST_RANGE;
            end else if (any_split && (r_count >= CNT_MAX)) begin
                ex_status = ST_FULL;
            end
        end else begin
            if (r_re > {1'b0, r_eff}) begin
                ex_status = ST_RANGE;
            end else if (!any_touch && (r_count >= CNT_MAX)) begin
                ex_status = ST_FULL;
            end
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:   if (i_valid) n_state = S_EXEC;
            S_EXEC:   n_state = (ex_status == ST_OK) ? S_SETTLE : S_DONE;
            S_SETTLE: if (!any_hole && !any_merge) n_state = S_DONE;
            S_DONE:   if (out_free) n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    // chain command and bookkeeping
    always_comb begin
        ctl.op        = CELL_HOLD;
        ctl.split_any = any_split;
        ctl.hole_any  = any_hole;
        load_end      = r_eff;
        n_eff         = r_eff;
        n_count       = r_count;
        if (i_memory_size_we) begin
            n_eff    = sat_size(i_memory_size);
            load_end = n_eff;
            ctl.op   = CELL_LOAD;
            n_count  = (n_eff != '0) ? ICW'(1) : '0;
        end else begin
            unique case (r_state)
                S_EXEC: begin
                    if (ex_status == ST_OK) begin
                        if (r_cmd == CMD_ALLOC) begin
                            ctl.op = CELL_ALLOC;
                            if (any_drop) begin
                                n_count = r_count - ICW'(1);
                            end else if (any_split) begin
                                n_count = r_count + ICW'(1);
                            end
                        end else begin
                            ctl.op  = CELL_INSERT;
                            n_count = r_count + ICW'(1);
                        end
                    end
                end
                S_SETTLE: begin
                    if (any_hole || any_merge) begin
                        ctl.op = CELL_SETTLE;
                    end
                    if (!any_hole && any_merge) begin
                        n_count = r_count - ICW'(1);
                    end
                end
                default: begin
                    ctl.op = CELL_HOLD;
                end
            endcase
        end
    end

    always_comb begin
        n_ovalid = r_ovalid;
        if ((r_state == S_DONE) && out_free) begin
            n_ovalid = 1'b1;
        end else if (!i_stall) begin
            n_ovalid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_eff    <= RST_END;
            r_count  <= ICW'(1);
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_eff    <= n_eff;
            r_count  <= n_count;
            r_ovalid <= n_ovalid;
        end
    end

    // command word and result payload
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cmd  <= i_cmd;
            r_zero <= (i_range_length == '0);
            r_rs   <= i_range_start;
            r_re   <= (ADDR_BITS+2)'(i_range_start) + (ADDR_BITS+2)'(i_range_length);
        end
        if (r_state == S_EXEC) begin
            r_status <= ex_status;
        end
        if ((r_state == S_DONE) && out_free) begin
            r_ostatus <= r_status;
            r_ocount  <= r_count[CNT_W-1:0];
        end
    end

    assign o_stall        = (r_state != S_IDLE);
    assign o_valid        = r_ovalid;
    assign o_status       = r_ostatus;
    assign o_extent_count = r_ocount;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> (r_count <= CNT_MAX))
        else $error("extent count above table size");

    a_one_container: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EXEC) |-> $onehot0(contain_v))
        else $error("more than one extent contains the range");

    a_bottom_matches_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> (w_link[0].valid == (r_count != '0)))
        else $error("bottom slot disagrees with extent count");

    a_accept_to_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (r_state == S_EXEC))
        else $error("accepted word not evaluated");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_status == ST_OK || o_status == ST_RANGE || o_status == ST_FULL))
        else $error("undefined status code");
`endif

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 1ps
// testbench for free_extent_range_allocator: directed and random allocate / free words
// depends on fera_pkg and the allocator rtl; the class below predicts status and count
module tb;
    import fera_pkg::*;

    localparam int MAX_EXTENTS = 64;
    localparam int ADDR_BITS   = 16;
    localparam int CNT_W       = $clog2(MAX_EXTENTS + 1);
    localparam int IDLE_LIMIT  = 40000;
    localparam int ADDR_SPAN   = 1 << ADDR_BITS;

    typedef struct {
        logic [1:0]       status;
        logic [CNT_W-1:0] count;
    } t_extent_result;

    // keeps its own sorted table of free extents and the results still owed
    class extent_scoreboard;
        int unsigned    free_start[$];
        int unsigned    free_len[$];
        int unsigned    usable_size;
        t_extent_result owed[$];
        int             mismatches;

        function void reload(int unsigned size);
            usable_size = (size > ADDR_SPAN) ? ADDR_SPAN : size;
            free_start.delete();
            free_len.delete();
            if (usable_size != 0) begin
                free_start.push_back(0);
                free_len.push_back(usable_size);
            end
        endfunction

        function logic [1:0] carve(int unsigned rs, int unsigned rl);
            int unsigned re;
            int unsigned s;
            int unsigned e;
            re = rs + rl;
            for (int i = 0; i < free_start.size(); i++) begin
                s = free_start[i];
                e = s + free_len[i];
                if (rs >= s && re <= e) begin
                    if (rs == s && re == e) begin
                        free_start.delete(i);
                        free_len.delete(i);
                    end else if (rs == s) begin
                        free_start[i] = re;
                        free_len[i]   = e - re;
                    end else if (re == e) begin
                        free_len[i] = rs - s;
                    end else begin
                        if (free_start.size() >= MAX_EXTENTS) return ST_FULL;
                        free_len[i] = rs - s;
                        free_start.insert(i + 1, re);
                        free_len.insert(i + 1, e - re);
                    end
                    return ST_OK;
                end
            end
            return ST_RANGE;
        endfunction

        function logic [1:0] release_range(int unsigned rs, int unsigned rl);
            int unsigned ts[$];
            int unsigned tl[$];
            int unsigned ms[$];
            int unsigned ml[$];
            bit          placed;
            int unsigned pe;
            int unsigned ce;
            placed = 0;
            if (rs + rl > usable_size) return ST_RANGE;
            foreach (free_start[i]) begin
                if (!placed && free_start[i] > rs) begin
                    ts.push_back(rs);
                    tl.push_back(rl);
                    placed = 1;
                end
                ts.push_back(free_start[i]);
                tl.push_back(free_len[i]);
            end
            if (!placed) begin
                ts.push_back(rs);
                tl.push_back(rl);
            end
            // union of touching or overlapping neighbors
            ms.push_back(ts[0]);
            ml.push_back(tl[0]);
            for (int i = 1; i < ts.size(); i++) begin
                pe = ms[$] + ml[$];
                ce = ts[i] + tl[i];
                if (pe >= ts[i]) begin
                    if (ce > pe) ml[ml.size()-1] = ce - ms[$];
                end else begin
                    ms.push_back(ts[i]);
                    ml.push_back(tl[i]);
                end
            end
            if (ms.size() > MAX_EXTENTS) return ST_FULL;
            free_start = ms;
            free_len   = ml;
            return ST_OK;
        endfunction

        function void note_word(logic cmd, int unsigned rs, int unsigned rl);
            t_extent_result r;
            if (rl == 0) r.status = ST_RANGE;
            else if (cmd == CMD_ALLOC) r.status = carve(rs, rl);
            else r.status = release_range(rs, rl);
            r.count = CNT_W'(free_start.size());
            owed.push_back(r);
        endfunction

        function void check_word(logic [1:0] status, logic [CNT_W-1:0] count);
            t_extent_result r;
            if (owed.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: status %0d count %0d", status, count);
                return;
            end
            r = owed.pop_front();
            if (r.status !== status || r.count !== count) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: status exp %0d got %0d, count exp %0d got %0d",
                             r.status, status, r.count, count);
            end
        endfunction
    endclass

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   i_memory_size_we;
    logic [ADDR_BITS:0]     i_memory_size;
    logic                   i_valid;
    logic                   o_stall;
    logic                   i_cmd;
    logic [ADDR_BITS-1:0]   i_range_start;
    logic [ADDR_BITS:0]     i_range_length;
    logic                   o_valid;
    logic                   i_stall;
    logic [1:0]             o_status;
    logic [CNT_W-1:0]       o_extent_count;

    extent_scoreboard sb;
    int               idle_cycles;
    int               burst_left;

    free_extent_range_allocator #(
        .MAX_EXTENTS(MAX_EXTENTS),
        .ADDR_BITS  (ADDR_BITS)
    ) u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_memory_size_we(i_memory_size_we),
        .i_memory_size   (i_memory_size),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_cmd           (i_cmd),
        .i_range_start   (i_range_start),
        .i_range_length  (i_range_length),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_status        (o_status),
        .o_extent_count  (o_extent_count)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // result side: compare every delivered result against the oldest prediction
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) sb.check_word(o_status, o_extent_count);
    end

    // watchdog: cycles with no word moving on either channel
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles > IDLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    // receiver stall: a randomly chosen pattern, picked anew again and again, sometimes never stalling
    initial begin
        int mode;
        i_stall = 1'b0;
        forever begin
            mode = $urandom_range(0, 3);
            for (int c = 0; c < 40; c++) begin
                @(negedge i_clk);
                case (mode)
                    0: i_stall <= 1'b0;
                    1: i_stall <= ($urandom_range(0, 1) == 1);
                    2: i_stall <= (c % 7) < 3;
                    default: i_stall <= ($urandom_range(0, 9) == 0);
                endcase
            end
        end
    end

    // called at a falling edge; returns at the falling edge after acceptance
    task automatic send_word(logic cmd, int unsigned rs, int unsigned rl);
        i_valid        <= 1'b1;
        i_cmd          <= cmd;
        i_range_start  <= rs[ADDR_BITS-1:0];
        i_range_length <= rl[ADDR_BITS:0];
        do @(posedge i_clk); while (o_stall);
        sb.note_word(cmd, rs[ADDR_BITS-1:0], rl[ADDR_BITS:0]);
        @(negedge i_clk);
    endtask

    // sender bursts: a random gap with valid low, then a run of back to back words
    task automatic paced_word(logic cmd, int unsigned rs, int unsigned rl);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 20);
            gap = $urandom_range(0, 6);
            if (gap != 0) begin
                i_valid <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
        end
        burst_left--;
        send_word(cmd, rs, rl);
    endtask

    // drain all owed results, let the chain settle, then reload the table
    task automatic write_size(int unsigned size);
        i_valid <= 1'b0;
        while (sb.owed.size() != 0) @(negedge i_clk);
        repeat (8) @(negedge i_clk);
        i_memory_size_we <= 1'b1;
        i_memory_size    <= size[ADDR_BITS:0];
        sb.reload(size[ADDR_BITS:0]);
        @(negedge i_clk);
        i_memory_size_we <= 1'b0;
        burst_left = 0;
    endtask

    // mostly ranges carved out of a live extent or freed back inside memory
    task automatic random_word();
        int unsigned pick;
        int unsigned idx;
        int unsigned s;
        int unsigned l;
        int unsigned rs;
        int unsigned rl;
        pick = $urandom_range(0, 99);
        if (pick < 55 && sb.free_start.size() != 0) begin
            idx = $urandom_range(0, sb.free_start.size() - 1);
            s   = sb.free_start[idx];
            l   = sb.free_len[idx];
            rs  = s + $urandom_range(0, l - 1);
            rl  = $urandom_range(1, (s + l - rs) > 8 ? 8 : (s + l - rs));
            if ($urandom_range(0, 4) == 0) rl = s + l - rs;
            paced_word(CMD_ALLOC, rs, rl);
        end else if (pick < 90 && sb.usable_size != 0) begin
            rs = $urandom_range(0, sb.usable_size - 1);
            l  = sb.usable_size - rs;
            rl = $urandom_range(1, l > 12 ? 12 : l);
            paced_word(CMD_FREE, rs, rl);
        end else begin
            paced_word(1'($urandom_range(0, 1)), $urandom_range(0, ADDR_SPAN - 1),
                       $urandom_range(0, 2 * ADDR_SPAN - 1));
        end
    endtask

    initial begin
        int unsigned sizes[6];
        sb = new();
        sb.mismatches    = 0;
        idle_cycles      = 0;
        burst_left       = 0;
        i_rst_n          = 1'b0;
        i_memory_size_we = 1'b0;
        i_memory_size    = '0;
        i_valid          = 1'b0;
        i_cmd            = CMD_ALLOC;
        i_range_start    = '0;
        i_range_length   = '0;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        sb.reload(ADDR_SPAN);
        @(negedge i_clk);

        // directed: extremes, trims, splits, rejects and merges
        send_word(CMD_ALLOC, 0, 0);                    // zero length
        send_word(CMD_FREE, 5, 0);
        send_word(CMD_ALLOC, 0, ADDR_SPAN);            // whole memory
        send_word(CMD_FREE, 0, ADDR_SPAN);
        send_word(CMD_ALLOC, 100, 10);                 // split
        send_word(CMD_ALLOC, 0, 5);                    // trim left
        send_word(CMD_ALLOC, ADDR_SPAN - 1, 1);        // trim right
        send_word(CMD_ALLOC, 105, 2);                  // outside every extent
        send_word(CMD_FREE, ADDR_SPAN - 1, 2);         // past the end
        send_word(CMD_ALLOC, ADDR_SPAN - 1, 2 * ADDR_SPAN - 1);
        send_word(CMD_FREE, 50, 100);                  // overlaps free units
        send_word(CMD_FREE, 0, ADDR_SPAN);             // merge everything
        send_word(CMD_ALLOC, 5, 5);
        send_word(CMD_ALLOC, 10, ADDR_SPAN - 10);      // drop an extent
        send_word(CMD_FREE, 5, 5);

        write_size(0);                                 // empty table
        send_word(CMD_ALLOC, 0, 1);
        send_word(CMD_FREE, 0, 1);
        write_size(2 * ADDR_SPAN - 1);                 // saturated size
        send_word(CMD_FREE, ADDR_SPAN - 1, 1);
        send_word(CMD_ALLOC, ADDR_SPAN - 2, 2);
        write_size(1);
        send_word(CMD_ALLOC, 0, 1);
        send_word(CMD_FREE, 0, 1);

        // fill the table with gaps of three units, then hit both full cases
        write_size(320);
        for (int k = 0; k < 64; k++) paced_word(CMD_ALLOC, 5 * k + 1, 3);
        paced_word(CMD_FREE, 7, 1);                    // would add a 65th extent
        paced_word(CMD_FREE, 1, 3);                    // closes a gap
        write_size(320);

        // random phases over several memory sizes; size 16 keeps only small tables
        sizes = '{ADDR_SPAN, 300, 1000, 2 * ADDR_SPAN - 1, 16, 0};
        sizes[5] = $urandom_range(1, 2 * ADDR_SPAN - 1);
        foreach (sizes[p]) begin
            write_size(sizes[p]);
            for (int n = 0; n < 130; n++) random_word();
        end

        i_valid <= 1'b0;
        while (sb.owed.size() != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
        if (sb.mismatches == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
